// ===== sv/atcs_pkg.sv =====
// Package for the AT-command sequencer: payload structs, state codes and byte tables.
// Used by at_command_sequencer_top; depends on nothing else.
`default_nettype none
package atcs_pkg;

  localparam int ReplyBytes   = 128;
  localparam int MessageBytes = 32;
  localparam int ReplyAw      = $clog2(ReplyBytes);
  localparam int MsgAw        = $clog2(MessageBytes);

  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdRx   = 2'd1;
  localparam logic [1:0] CmdMsg  = 2'd2;

  localparam logic [3:0] SeqIdle    = 4'd0;
  localparam logic [3:0] SeqAt      = 4'd1;
  localparam logic [3:0] SeqCmgs    = 4'd6;
  localparam logic [3:0] SeqText    = 4'd7;
  localparam logic [3:0] SeqWait    = 4'd8;
  localparam logic [3:0] SeqError   = 4'd9;
  localparam logic [3:0] SeqSuccess = 4'd10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       run_last;
    logic [3:0] sequence_state;
  } out_item_t;

  // Command text for sending states 1..6, without CR LF.
  function automatic logic [7:0] cmd_byte(input logic [5:0] idx);
    logic [7:0] r;
    case (idx)
      6'd0: r = 8'h41;  6'd1: r = 8'h54;
      6'd2: r = 8'h41;  6'd3: r = 8'h54;  6'd4: r = 8'h49;
      6'd5: r = 8'h41;  6'd6: r = 8'h54;  6'd7: r = 8'h2B;  6'd8: r = 8'h43;
      6'd9: r = 8'h50;  6'd10: r = 8'h49; 6'd11: r = 8'h4E; 6'd12: r = 8'h3F;
      6'd13: r = 8'h41; 6'd14: r = 8'h54; 6'd15: r = 8'h2B; 6'd16: r = 8'h43;
      6'd17: r = 8'h52; 6'd18: r = 8'h45; 6'd19: r = 8'h47; 6'd20: r = 8'h3F;
      6'd21: r = 8'h41; 6'd22: r = 8'h54; 6'd23: r = 8'h2B; 6'd24: r = 8'h43;
      6'd25: r = 8'h4D; 6'd26: r = 8'h47; 6'd27: r = 8'h46; 6'd28: r = 8'h3D;
      6'd29: r = 8'h31;
      6'd30: r = 8'h41; 6'd31: r = 8'h54; 6'd32: r = 8'h2B; 6'd33: r = 8'h43;
      6'd34: r = 8'h4D; 6'd35: r = 8'h47; 6'd36: r = 8'h53; 6'd37: r = 8'h3D;
      6'd38: r = 8'h22; 6'd39: r = 8'h33; 6'd40: r = 8'h31; 6'd41: r = 8'h30;
      6'd42: r = 8'h37; 6'd43: r = 8'h34; 6'd44: r = 8'h38; 6'd45: r = 8'h33;
      6'd46: r = 8'h32; 6'd47: r = 8'h37; 6'd48: r = 8'h33; 6'd49: r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] cmd_off(input logic [2:0] c);
    logic [5:0] r;
    case (c)
      3'd0: r = 6'd0;  3'd1: r = 6'd2;  3'd2: r = 6'd5;
      3'd3: r = 6'd13; 3'd4: r = 6'd21; 3'd5: r = 6'd30;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] cmd_len(input logic [2:0] c);
    logic [4:0] r;
    case (c)
      3'd0: r = 5'd2;  3'd1: r = 5'd3;  3'd2: r = 5'd8;
      3'd3: r = 5'd8;  3'd4: r = 5'd9;  3'd5: r = 5'd20;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Expected reply text for awaited states 1..7.
  function automatic logic [7:0] ans_byte(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0: r = 8'h4F;  5'd1: r = 8'h4B;
      5'd2: r = 8'h45;  5'd3: r = 8'h43;  5'd4: r = 8'h32;  5'd5: r = 8'h35;
      5'd6: r = 8'h52;  5'd7: r = 8'h45;  5'd8: r = 8'h41;  5'd9: r = 8'h44;
      5'd10: r = 8'h59;
      5'd11: r = 8'h30; 5'd12: r = 8'h2C; 5'd13: r = 8'h31;
      5'd14: r = 8'h4F; 5'd15: r = 8'h4B;
      5'd16: r = 8'h3E;
      5'd17: r = 8'h4F; 5'd18: r = 8'h4B;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] ans_off(input logic [2:0] c);
    logic [4:0] r;
    case (c)
      3'd0: r = 5'd0;  3'd1: r = 5'd2;  3'd2: r = 5'd6;  3'd3: r = 5'd11;
      3'd4: r = 5'd14; 3'd5: r = 5'd16; 3'd6: r = 5'd17;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ans_len(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0: r = 3'd2; 3'd1: r = 3'd4; 3'd2: r = 3'd5; 3'd3: r = 3'd3;
      3'd4: r = 3'd2; 3'd5: r = 3'd1; 3'd6: r = 3'd2;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] err_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h45;  4'd1: r = 8'h43;  4'd2: r = 8'h32;  4'd3: r = 8'h30;
      4'd4: r = 8'h30;  4'd5: r = 8'h54;  4'd6: r = 8'h20;  4'd7: r = 8'h45;
      4'd8: r = 8'h52;  4'd9: r = 8'h52;  4'd10: r = 8'h4F; 4'd11: r = 8'h52;
      4'd12: r = 8'h0D; 4'd13: r = 8'h0A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/at_command_sequencer_top.sv =====
// Top level of the AT-command sequencer: sequencer, message and reply memories, output register.
// Depends on atcs_pkg.
`default_nettype none
// One transfer in is handled at a time. A receive byte or message byte gives one result. A
// tick in a sending state emits its command, CR LF (and 0x1A after the text) one byte per
// cycle while the output is not stalled. A judging tick first walks the reply memory to find
// its end, one byte per cycle, then checks each start position with one shared byte
// comparator. Each compare has a read step and a compare step, and the judging tick ends
// early on a match. The error tick emits its 14-byte line one byte per cycle while the
// output is not stalled. Input stall is high while an item is in work or its results wait.
module at_command_sequencer_top
  import atcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StDecode = 10'b0000000010,
    StCmd    = 10'b0000000100,
    StText   = 10'b0000001000,
    StTail   = 10'b0000010000,
    StErr    = 10'b0000100000,
    StEnd    = 10'b0001000000,
    StScan   = 10'b0010000000,
    StCmp    = 10'b0100000000,
    StEmit   = 10'b1000000000
  } fsm_e;

  fsm_e        fsm_q;
  in_item_t    item_q;
  logic [7:0]  limit_q;
  logic [3:0]  cur_q, pend_q;
  logic [7:0]  idle_q;
  logic        bst_q;
  logic [ReplyAw:0] rcnt_q;
  logic [MsgAw:0]   mlen_q;
  logic [5:0]  idx_q;
  logic [ReplyAw:0] end_q, start_q;
  logic [2:0]  k_q;
  logic [2:0]  ans_c;
  logic        emit_wait;
  logic [MsgAw:0]   msg_wa;

  logic [7:0] msg_mem [MessageBytes];
  logic [7:0] rep_mem [ReplyBytes];
  logic [7:0] msg_rd_q, rep_rd_q;
  logic [MsgAw-1:0] msg_ra;
  logic [ReplyAw-1:0] rep_ra;

  assign in_stall_o = (fsm_q != StIdle) || out_valid_o;
  assign ans_c = pend_q[2:0] - 3'd1;
  assign emit_wait = out_valid_o && out_stall_i;
  assign msg_wa = (cur_q != SeqIdle) ? '0 : mlen_q;

  always_ff @(posedge clk_i) begin
    msg_rd_q <= msg_mem[msg_ra];
    rep_rd_q <= rep_mem[rep_ra];
    if (fsm_q == StDecode && item_q.command == CmdMsg && msg_wa < (MsgAw+1)'(MessageBytes)) begin
      msg_mem[msg_wa[MsgAw-1:0]] <= item_q.data_byte;
    end
    if (fsm_q == StDecode && item_q.command == CmdRx && cur_q == SeqWait &&
        rcnt_q < (ReplyAw+1)'(ReplyBytes)) begin
      rep_mem[rcnt_q[ReplyAw-1:0]] <= item_q.data_byte;
    end
  end

  // Read addresses are presented in the cycle before their data is used, as the reads are registered.
  always_comb begin
    logic [ReplyAw:0] a;
    msg_ra = idx_q[MsgAw-1:0];
    if (fsm_q == StText && !emit_wait) msg_ra = MsgAw'(idx_q + 6'd1);
    if (fsm_q == StDecode) msg_ra = '0;
    a = start_q + (ReplyAw+1)'(k_q);
    if (fsm_q == StScan && !(out_valid_o)) a = end_q + 1'b1;
    rep_ra = a[ReplyAw-1:0];
    if (fsm_q == StDecode) rep_ra = '0;
    if (fsm_q == StCmp) begin
      rep_ra = a[ReplyAw-1:0];
    end
  end

  logic [ReplyAw:0] cmp_next;
  logic             scan_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= StIdle; limit_q <= 8'd5; cur_q <= SeqIdle; pend_q <= SeqIdle;
      idle_q <= '0; bst_q <= 1'b0; rcnt_q <= '0; mlen_q <= '0;
      idx_q <= '0; end_q <= '0; start_q <= '0; k_q <= '0;
      out_valid_o <= 1'b0; out_data_o <= '0; item_q <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (fsm_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            item_q <= in_data_i;
            fsm_q <= StDecode;
          end
        end
        StDecode: begin
          idx_q <= '0;
          if (item_q.command == CmdTick) begin
            if (cur_q >= SeqAt && cur_q <= SeqCmgs) begin
              rcnt_q <= '0; pend_q <= cur_q; idle_q <= '0; bst_q <= 1'b0;
              fsm_q <= StCmd;
            end else if (cur_q == SeqText) begin
              pend_q <= SeqText; idle_q <= '0; bst_q <= 1'b0;
              fsm_q <= (mlen_q == '0) ? StTail : StText;
            end else if (cur_q == SeqWait) begin
              logic [7:0] ni;
              ni = bst_q ? 8'd0 : ((idle_q != 8'hFF) ? idle_q + 8'd1 : idle_q);
              idle_q <= ni; bst_q <= 1'b0;
              if (ni > limit_q) begin
                if (pend_q >= SeqAt && pend_q <= SeqText) begin
                  end_q <= '0; fsm_q <= StScan;
                end else begin
                  cur_q <= SeqIdle; pend_q <= SeqIdle; idle_q <= '0;
                  rcnt_q <= '0; mlen_q <= '0; fsm_q <= StEnd;
                end
              end else fsm_q <= StEnd;
            end else if (cur_q == SeqError) begin
              fsm_q <= StErr;
            end else begin
              if (cur_q != SeqIdle && cur_q != SeqSuccess) begin
                cur_q <= SeqIdle; pend_q <= SeqIdle; idle_q <= '0; bst_q <= 1'b0;
                rcnt_q <= '0; mlen_q <= '0;
              end
              fsm_q <= StEnd;
            end
          end else if (item_q.command == CmdRx) begin
            if (cur_q == SeqWait) begin
              if (rcnt_q < (ReplyAw+1)'(ReplyBytes)) rcnt_q <= rcnt_q + 1'b1;
              idle_q <= '0; bst_q <= 1'b1;
            end
            fsm_q <= StEnd;
          end else if (item_q.command == CmdMsg) begin
            logic [MsgAw:0] ml;
            ml = (cur_q != SeqIdle) ? '0 : mlen_q;
            if (ml < (MsgAw+1)'(MessageBytes)) ml = ml + 1'b1;
            mlen_q <= ml;
            if (cur_q != SeqIdle) begin
              cur_q <= SeqIdle; pend_q <= SeqIdle;
            end
            if (item_q.message_end) begin
              cur_q <= SeqAt; pend_q <= SeqIdle; idle_q <= '0; bst_q <= 1'b0;
            end
            fsm_q <= StEnd;
          end else begin
            fsm_q <= StEnd;
          end
        end
        StCmd: begin
          if (!emit_wait) begin
            logic [4:0] len;
            logic [7:0] b;
            len = cmd_len(pend_q[2:0] - 3'd1);
            if (idx_q < 6'(len)) b = cmd_byte(cmd_off(pend_q[2:0] - 3'd1) + idx_q);
            else if (idx_q == 6'(len)) b = 8'h0D;
            else b = 8'h0A;
            if (idx_q == 6'(len) + 6'd1) cur_q <= SeqWait;
            out_valid_o <= 1'b1;
            out_data_o <= '{byte_valid: 1'b1, tx_byte: b,
                            run_last: idx_q == 6'(len) + 6'd1,
                            sequence_state: SeqWait};
            idx_q <= idx_q + 6'd1;
            if (idx_q == 6'(len) + 6'd1) fsm_q <= StIdle;
          end
        end
        StText: begin
          if (!emit_wait) begin
            out_valid_o <= 1'b1;
            out_data_o <= '{byte_valid: 1'b1, tx_byte: msg_rd_q, run_last: 1'b0,
                            sequence_state: SeqWait};
            idx_q <= idx_q + 6'd1;
            if (idx_q + 6'd1 == 6'(mlen_q)) begin
              idx_q <= '0; fsm_q <= StTail;
            end
          end
        end
        StTail: begin
          if (!emit_wait) begin
            logic [7:0] b;
            b = (idx_q == 6'd0) ? 8'h0D : ((idx_q == 6'd1) ? 8'h0A : 8'h1A);
            out_valid_o <= 1'b1;
            out_data_o <= '{byte_valid: 1'b1, tx_byte: b, run_last: idx_q == 6'd2,
                            sequence_state: SeqWait};
            idx_q <= idx_q + 6'd1;
            if (idx_q == 6'd2) begin
              cur_q <= SeqWait; fsm_q <= StIdle;
            end
          end
        end
        StErr: begin
          if (!emit_wait) begin
            out_valid_o <= 1'b1;
            out_data_o <= '{byte_valid: 1'b1, tx_byte: err_byte(idx_q[3:0]),
                            run_last: idx_q == 6'd13, sequence_state: SeqIdle};
            idx_q <= idx_q + 6'd1;
            if (idx_q == 6'd13) begin
              cur_q <= SeqIdle; pend_q <= SeqIdle; idle_q <= '0; bst_q <= 1'b0;
              rcnt_q <= '0; mlen_q <= '0; fsm_q <= StIdle;
            end
          end
        end
        StScan: begin
          // Find the end of the stored reply: count or first zero byte.
          if (end_q >= rcnt_q || rep_rd_q == 8'h00) begin
            start_q <= '0; k_q <= '0;
            if ((ReplyAw+1)'(ans_len(ans_c)) > end_q) begin
              cur_q <= SeqError; fsm_q <= StEnd;
            end else fsm_q <= StCmp;
          end else begin
            end_q <= end_q + 1'b1;
          end
        end
        StCmp: begin
          // Read steps alternate with compare steps; each read step fetches the next byte to compare.
          if (scan_done) begin
            if (rep_rd_q == ans_byte(ans_off(ans_c) + 5'(k_q))) begin
              if (k_q + 3'd1 == ans_len(ans_c)) begin
                cur_q <= (pend_q == SeqText) ? SeqSuccess : pend_q + 4'd1;
                pend_q <= SeqWait; fsm_q <= StEnd;
              end else k_q <= k_q + 3'd1;
            end else if (cmp_next + (ReplyAw+1)'(ans_len(ans_c)) > end_q) begin
              cur_q <= SeqError; fsm_q <= StEnd;
            end else begin
              start_q <= cmp_next; k_q <= '0;
            end
          end
          idx_q <= scan_done ? 6'd0 : 6'd1;
        end
        StEnd: begin
          if (!emit_wait) begin
            out_valid_o <= 1'b1;
            out_data_o <= '{byte_valid: 1'b0, tx_byte: 8'h00, run_last: 1'b1,
                            sequence_state: cur_q};
            fsm_q <= StIdle;
          end
        end
        StEmit: fsm_q <= StIdle;
        default: fsm_q <= StIdle;
      endcase
    end
  end

  // Compare stage alternates between a read step and a compare step.
  assign cmp_next  = start_q + 1'b1;
  assign scan_done = (idx_q == 6'd1);

endmodule
`default_nettype wire
